/* hw/rtl/mhs_pkg.sv */
package mhs_pkg;

  localparam int KEY_W          = 31;
  localparam int BUCKET_FIELD_W = 4;

  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_LOOKUP  = 1'b1;
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic                      found;
    logic [BUCKET_FIELD_W-1:0] bucket;
    logic                      status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_FILL,
    ST_CHECK,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic mod_step;
    logic fill_rd;
    logic ins_wr;
    logic scan_first;
    logic scan_next;
    logic mark_found;
    logic mark_full;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic mod_last;
    logic is_lookup;
    logic full;
    logic empty;
    logic hit;
    logic scan_last;
  } dp_stat_t;

endpackage

/* hw/rtl/mhs_mod.sv */
module mhs_mod import mhs_pkg::*; #(
  parameter int BUCKETS = 16,
  parameter int BW      = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             step,
  input  logic [KEY_W-1:0] key,
  output logic [BW-1:0]    rem,
  output logic             last
);

  // reciprocal multiply: (key * MAGIC) >> SHIFT is the exact quotient for any key
  // below 2**KEY_W, and the remainder only needs the low BW bits of key - q * BUCKETS
  localparam int             SHIFT   = KEY_W + BW;
  localparam int             PROD_W  = 2 * KEY_W + 1;
  localparam logic [63:0]    MAGIC64 =
    ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [KEY_W:0] MAGIC   = MAGIC64[KEY_W:0];

  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [BW-1:0]     quo_r, quo_nxt;
  logic [BW-1:0]     rem_r, rem_nxt;
  logic              ph_r, ph_nxt;
  logic [PROD_W-1:0] prod;
  logic [BW-1:0]     quo_mul;

  assign prod    = PROD_W'(key_r) * PROD_W'(MAGIC);
  assign quo_mul = BW'(quo_r * BW'(BUCKETS));

  // first step forms the quotient, second step folds it back into the remainder
  always_comb begin
    key_nxt = key_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    ph_nxt  = ph_r;
    if (start) begin
      key_nxt = key;
      ph_nxt  = 1'b0;
    end else if (step) begin
      if (!ph_r) begin
        quo_nxt = BW'(prod >> SHIFT);
        ph_nxt  = 1'b1;
      end else begin
        rem_nxt = key_r[BW-1:0] - quo_mul;
        ph_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign rem  = rem_r;
  assign last = ph_r;

endmodule

/* hw/rtl/mhs_dp.sv */
module mhs_dp import mhs_pkg::*; #(
  parameter int BUCKETS = 16,
  parameter int SLOTS   = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat,
  output out_item_t out_data
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW    = $clog2(SLOTS + 1);
  localparam int DEPTH = BUCKETS * SLOTS;
  localparam int AW    = $clog2(DEPTH);

  logic [FW-1:0]    fill_mem [BUCKETS];
  logic [KEY_W-1:0] key_mem  [DEPTH];

  logic [BW-1:0]    clr_r;
  logic             action_r;
  logic [KEY_W-1:0] key_r;
  logic [FW-1:0]    fill_rd_r;
  logic [KEY_W-1:0] key_rd_r;
  logic [SW-1:0]    slot_r;
  logic             found_r;
  logic             full_r;
  out_item_t        out_data_r;

  logic [BW-1:0] bucket;
  logic          mod_last;
  logic [SW-1:0] rd_slot;
  logic [AW-1:0] base_addr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  mhs_mod #(
    .BUCKETS (BUCKETS),
    .BW      (BW)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.load),
    .step  (cmd.mod_step),
    .key   (in_data.key),
    .rem   (bucket),
    .last  (mod_last)
  );

  assign rd_slot   = cmd.scan_first ? '0 : SW'(slot_r + 1'b1);
  assign base_addr = AW'(bucket) * AW'(SLOTS);
  assign wr_addr   = base_addr + AW'(fill_rd_r[SW-1:0]);
  assign rd_addr   = base_addr + AW'(rd_slot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear_step) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      fill_mem[clr_r] <= '0;
    end else if (cmd.ins_wr) begin
      fill_mem[bucket] <= fill_rd_r + FW'(1);
    end
    if (cmd.fill_rd) begin
      fill_rd_r <= fill_mem[bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_wr) begin
      key_mem[wr_addr] <= key_r;
    end
    if (cmd.scan_first || cmd.scan_next) begin
      key_rd_r <= key_mem[rd_addr];
      slot_r   <= rd_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_data.action;
      key_r    <= in_data.key;
      found_r  <= 1'b0;
      full_r   <= STATUS_DONE;
    end else begin
      if (cmd.mark_found) begin
        found_r <= 1'b1;
      end
      if (cmd.mark_full) begin
        full_r <= STATUS_FULL;
      end
    end
    if (cmd.out_load) begin
      out_data_r.found  <= found_r;
      out_data_r.bucket <= BUCKET_FIELD_W'(bucket);
      out_data_r.status <= full_r;
    end
  end

  assign stat.clear_last = (clr_r == BW'(BUCKETS - 1));
  assign stat.mod_last   = mod_last;
  assign stat.is_lookup  = (action_r == ACT_LOOKUP);
  assign stat.full       = (fill_rd_r >= FW'(SLOTS));
  assign stat.empty      = (fill_rd_r == '0);
  assign stat.hit        = (key_rd_r == key_r);
  assign stat.scan_last  = ((FW'(slot_r) + FW'(1)) == fill_rd_r);

  assign out_data = out_data_r;

endmodule

/* hw/rtl/mhs_ctrl.sv */
module mhs_ctrl import mhs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.fill_rd = 1'b1;
        state_nxt   = ST_CHECK;
      end
      ST_CHECK: begin
        if (!stat.is_lookup) begin
          if (stat.full) begin
            cmd.mark_full = 1'b1;
          end else begin
            cmd.ins_wr = 1'b1;
          end
          state_nxt = ST_RESULT;
        end else if (stat.empty) begin
          state_nxt = ST_RESULT;
        end else begin
          cmd.scan_first = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // compare the slot read last cycle, fetch the next one if needed
        if (stat.hit) begin
          cmd.mark_found = 1'b1;
          state_nxt      = ST_RESULT;
        end else if (stat.scan_last) begin
          state_nxt = ST_RESULT;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/modulo_hash_set_insert_lookup.sv */
// Bounded-bucket hash set: key goes to bucket key mod BUCKETS, each bucket holds up to
// SLOTS keys in insertion order, duplicates allowed; an insert into a full bucket is
// refused with status 1, a lookup reports found. One transaction is worked at a time:
// accept, the remainder unit (reciprocal multiply, then fold back), one fill-count
// RAM read, a decision step and a result step; a lookup also compares stored keys
// (one key RAM read per cycle), stopping at the first match or the last stored key.
// The result waits in an output register, so a new transaction is accepted while it is
// unclaimed; the next result then holds in its result state until out_stall lets the
// previous one go.
// After reset the fill-count RAM is cleared bucket by bucket, during which in_stall is high.
module modulo_hash_set_insert_lookup import mhs_pkg::*; #(
  parameter int BUCKETS = 16,
  parameter int SLOTS   = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  mhs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mhs_dp #(
    .BUCKETS (BUCKETS),
    .SLOTS   (SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

/* hw/rtl/mhs_checker.sv */
module mhs_checker import mhs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // block is busy clearing right after reset, nothing pending
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("transaction accepted or result shown right after reset");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction accepted back to back");

  // the remainder steps lie between accept and result, so no result can appear at once
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result raised in the cycle after accept");

  // a refused insert never reports a hit
  a_found_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.found && (out_data.status == STATUS_FULL)))
    else $error("result both found and refused");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

endmodule

bind modulo_hash_set_insert_lookup mhs_checker u_mhs_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import mhs_pkg::*;

  localparam int NUM_BUCKETS = 16;
  localparam int NUM_SLOTS   = 8;
  localparam int RAND_OPS    = 500;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic             action;
    logic [KEY_W-1:0] key;
    bit               typed;
    out_item_t        want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // shadow copy of the hash set
  int unsigned      fill_cnt [NUM_BUCKETS];
  logic [KEY_W-1:0] slot_key [NUM_BUCKETS][NUM_SLOTS];

  out_item_t        pending_q [$];
  logic [KEY_W-1:0] key_pool [$];
  dir_row_t         dir_tab [$];
  int               err_count;
  int               idle_cycles;
  bit               quiet;
  int               stall_left;

  modulo_hash_set_insert_lookup #(
    .BUCKETS(NUM_BUCKETS),
    .SLOTS  (NUM_SLOTS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic out_item_t hash_set_apply(in_item_t op);
    out_item_t   res;
    int unsigned b;
    b          = op.key % NUM_BUCKETS;
    res.found  = 1'b0;
    res.bucket = b[BUCKET_FIELD_W-1:0];
    res.status = STATUS_DONE;
    if (op.action == ACT_INSERT) begin
      if (fill_cnt[b] >= NUM_SLOTS) begin
        res.status = STATUS_FULL;
      end else begin
        slot_key[b][fill_cnt[b]] = op.key;
        fill_cnt[b]++;
      end
    end else begin
      for (int i = 0; i < fill_cnt[b]; i++) begin
        if (slot_key[b][i] == op.key) res.found = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $time, msg);
    err_count++;
  endtask

  function automatic void add_row(logic act, logic [KEY_W-1:0] k, bit typed,
                                  logic f, logic [BUCKET_FIELD_W-1:0] b, logic s);
    dir_row_t row;
    row.action      = act;
    row.key         = k;
    row.typed       = typed;
    row.want.found  = f;
    row.want.bucket = b;
    row.want.status = s;
    dir_tab.push_back(row);
  endfunction

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 60) return 0;
    if (pick < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int               pick;
    logic [KEY_W-1:0] k;
    pick = $urandom_range(0, 99);
    k    = KEY_W'($urandom);
    if (key_pool.size() == 0) return k;
    if (pick < 45) return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (pick < 70) return KEY_W'($urandom_range(0, 255));
    if (pick < 85) begin
      // lands in the bucket of a stored key, with random upper bits
      k[BUCKET_FIELD_W-1:0] =
        key_pool[$urandom_range(0, key_pool.size() - 1)][BUCKET_FIELD_W-1:0];
    end
    return k;
  endfunction

  task automatic send_op(input in_item_t op, input bit typed, input out_item_t want);
    int        gap;
    out_item_t res;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data  <= in_item_t'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = hash_set_apply(op);
    pending_q.push_back(typed ? want : res);
    if (op.action == ACT_INSERT) key_pool.push_back(op.key);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles = idle_cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_data));
      end else begin
        want = pending_q.pop_front();
        if (out_data.found !== want.found)
          report_mismatch($sformatf("found %b, want %b", out_data.found, want.found));
        if (out_data.bucket !== want.bucket)
          report_mismatch($sformatf("bucket %0d, want %0d", out_data.bucket, want.bucket));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %b, want %b", out_data.status, want.status));
      end
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    int pick;
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      pick = $urandom_range(0, 99);
      if (!quiet) begin
        if (pick < 20) stall_left = $urandom_range(1, 3);
        else if (pick < 23) stall_left = $urandom_range(10, 40);
      end
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    in_item_t  op;
    out_item_t no_want;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    quiet       = 1'b0;
    stall_left  = 0;
    err_count   = 0;
    idle_cycles = 0;
    no_want     = '0;
    foreach (fill_cnt[i]) fill_cnt[i] = 0;

    // empty set, extreme keys, duplicate, full bucket
    add_row(ACT_LOOKUP, 31'd0,          1, 1'b0, 4'd0,  STATUS_DONE);
    add_row(ACT_LOOKUP, 31'h7FFF_FFFF,  1, 1'b0, 4'd15, STATUS_DONE);
    add_row(ACT_INSERT, 31'h7FFF_FFFF,  1, 1'b0, 4'd15, STATUS_DONE);
    add_row(ACT_LOOKUP, 31'h7FFF_FFFF,  1, 1'b1, 4'd15, STATUS_DONE);
    for (int i = 0; i < NUM_SLOTS; i++)
      add_row(ACT_INSERT, 31'(16 * i),  1, 1'b0, 4'd0,  STATUS_DONE);
    add_row(ACT_INSERT, 31'd128,        1, 1'b0, 4'd0,  STATUS_FULL);
    add_row(ACT_LOOKUP, 31'd112,        1, 1'b1, 4'd0,  STATUS_DONE);
    add_row(ACT_LOOKUP, 31'd128,        1, 1'b0, 4'd0,  STATUS_DONE);
    add_row(ACT_INSERT, 31'h7FFF_FFFF,  1, 1'b0, 4'd15, STATUS_DONE);
    add_row(ACT_LOOKUP, 31'h7FFF_FFF0,  0, 1'b0, 4'd0,  STATUS_DONE);
    add_row(ACT_INSERT, 31'h5555_5555,  0, 1'b0, 4'd0,  STATUS_DONE);
    add_row(ACT_INSERT, 31'h2AAA_AAAA,  0, 1'b0, 4'd0,  STATUS_DONE);
    add_row(ACT_LOOKUP, 31'h5555_5555,  0, 1'b0, 4'd0,  STATUS_DONE);
    add_row(ACT_LOOKUP, 31'h2AAA_AAAA,  0, 1'b0, 4'd0,  STATUS_DONE);
    add_row(ACT_LOOKUP, 31'h2AAA_AAA5,  0, 1'b0, 4'd0,  STATUS_DONE);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      op.action = dir_tab[i].action;
      op.key    = dir_tab[i].key;
      send_op(op, dir_tab[i].typed, dir_tab[i].want);
    end
    wait_drained();

    for (int n = 0; n < RAND_OPS; n++) begin
      if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (n == RAND_OPS / 2) wait_drained();
      op.action = ($urandom_range(0, 99) < 55) ? ACT_LOOKUP : ACT_INSERT;
      op.key    = pick_key();
      send_op(op, 1'b0, no_want);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/mhs_pkg.sv
hw/rtl/mhs_mod.sv
hw/rtl/mhs_dp.sv
hw/rtl/mhs_ctrl.sv
hw/rtl/modulo_hash_set_insert_lookup.sv
hw/rtl/mhs_checker.sv
bench/tb_top.sv
